// ----- rtl/short_descriptor_page_walker_macros.svh -----
// assertion macros for the short-descriptor page walker
// used by the top level only, no other dependencies
`ifndef SHORT_DESCRIPTOR_PAGE_WALKER_MACROS_SVH
`define SHORT_DESCRIPTOR_PAGE_WALKER_MACROS_SVH

// same-cycle implication under reset
`define SDPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SDPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sdpw_pkg.sv -----
// shared types and constants of the short-descriptor page walker
// no dependencies
package sdpw_pkg;

    localparam int PAGE_BITS = 12;
    localparam int FRAME_W   = 32 - PAGE_BITS;
    localparam int PADDR_W   = 4;

    typedef enum logic [1:0] {
        KIND_READ       = 2'd0,
        KIND_DONE       = 2'd1,
        KIND_FAULT      = 2'd2,
        KIND_UNEXPECTED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_IDLE   = 2'd0,
        PHASE_FIRST  = 2'd1,
        PHASE_SECOND = 2'd2
    } phase_t;

    localparam logic [1:0] DESC_FAULT = 2'b00;
    localparam logic [1:0] DESC_LINK  = 2'b01;

    localparam logic [1:0] REG_TTB0  = 2'd0;
    localparam logic [1:0] REG_TTB1  = 2'd1;
    localparam logic [1:0] REG_SPLIT = 2'd2;

    typedef struct packed {
        logic [31:0] table_base_zero;
        logic [31:0] table_base_one;
        logic [2:0]  split_width;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [31:0]        read_addr;
        logic [FRAME_W-1:0] frame_number;
        phase_t             phase_next;
        logic               capture_va;
    } step_t;

endpackage

// ----- rtl/sdpw_channels.sv -----
// valid/ready channel interfaces for walker requests and results
// depends on sdpw_pkg for the frame width
interface sdpw_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] virt_addr;
    logic [31:0] read_data;

    modport source (output valid, func, virt_addr, read_data, input ready);
    modport sink   (input valid, func, virt_addr, read_data, output ready);
endinterface

interface sdpw_out_if import sdpw_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [31:0]        read_addr;
    logic [FRAME_W-1:0] frame_number;

    modport source (output valid, result_kind, read_addr, frame_number, input ready);
    modport sink   (input valid, result_kind, read_addr, frame_number, output ready);
endinterface

// ----- rtl/sdpw_step.sv -----
// walk step decode: descriptor addresses, frame numbers and next phase
// depends on sdpw_pkg
module sdpw_step
    import sdpw_pkg::*;
(
    input  cfg_t        cfg,
    input  phase_t      phase,
    input  logic [31:0] held_va,
    input  logic        func,
    input  logic [31:0] virt_addr,
    input  logic [31:0] read_data,
    output step_t       res
);

    logic [31:0] top_mask;
    logic        use_one;
    logic [31:0] base0;
    logic [11:0] idx0;
    logic [31:0] l1_addr;
    logic [4:0]  low_bits;

    always_comb
    begin
        top_mask = ~(32'hFFFF_FFFF >> cfg.split_width);
        use_one  = (cfg.split_width != 3'd0) && ((virt_addr & top_mask) != 32'd0);
        low_bits = 5'd14 - {2'b00, cfg.split_width};
        base0    = cfg.table_base_zero & (32'hFFFF_FFFF << low_bits);
        idx0     = virt_addr[31:20] & (12'hFFF >> cfg.split_width);
        l1_addr  = use_one ? {cfg.table_base_one[31:14], virt_addr[31:20], 2'b00}
                           : (base0 | {18'd0, idx0, 2'b00});
    end

    always_comb
    begin
        res              = '0;
        res.kind         = KIND_UNEXPECTED;
        res.phase_next   = phase;
        if (!func)
        begin
            if (phase == PHASE_IDLE)
            begin
                res.kind       = KIND_READ;
                res.read_addr  = l1_addr;
                res.phase_next = PHASE_FIRST;
                res.capture_va = 1'b1;
            end
        end
        else
        begin
            case (phase)
                PHASE_FIRST:
                begin
                    res.phase_next = PHASE_IDLE;
                    case (read_data[1:0])
                        DESC_FAULT: res.kind = KIND_FAULT;
                        DESC_LINK:
                        begin
                            res.kind       = KIND_READ;
                            res.read_addr  = {read_data[31:10], held_va[19:12], 2'b00};
                            res.phase_next = PHASE_SECOND;
                        end
                        default:
                        begin
                            // supersections are not supported
                            if (read_data[18])
                            begin
                                res.kind = KIND_FAULT;
                            end
                            else
                            begin
                                res.kind         = KIND_DONE;
                                res.frame_number = {read_data[31:20], held_va[19:12]};
                            end
                        end
                    endcase
                end
                PHASE_SECOND:
                begin
                    res.phase_next = PHASE_IDLE;
                    case (read_data[1:0])
                        DESC_FAULT: res.kind = KIND_FAULT;
                        DESC_LINK:
                        begin
                            res.kind         = KIND_DONE;
                            res.frame_number = {read_data[31:16], held_va[15:12]};
                        end
                        default:
                        begin
                            res.kind         = KIND_DONE;
                            res.frame_number = read_data[31:12];
                        end
                    endcase
                end
                default: res.kind = KIND_UNEXPECTED;
            endcase
        end
    end

endmodule

// ----- rtl/short_descriptor_page_walker.sv -----
// top level of the short-descriptor page walker: apb registers, input and result stages
// depends on sdpw_pkg, sdpw_channels, sdpw_step and the assertion macro header
//
//  channel   dir   handshake     word
//  in_ch     in    valid/ready   func, virt_addr, read_data
//  out_ch    out   valid/ready   result_kind, read_addr, frame_number
//  apb       in    psel/penable  table_base_zero, table_base_one, split_width
//
// one word in per cycle unless the result stalls; words pass the input stage, then the result stage
// the walk phase and held address update as a word moves into the result stage
// a stalled result holds both stages; the input stage still takes a word while it is empty
// rst_n clears the apb registers, the held address, the phase and both stage valids
`include "short_descriptor_page_walker_macros.svh"

module short_descriptor_page_walker
    import sdpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    sdpw_in_if.sink            in_ch,
    sdpw_out_if.source         out_ch
);

    cfg_t               cfg_reg;
    phase_t             phase_reg;
    logic [31:0]        held_va_reg;

    logic               s1_valid_reg;
    logic               s1_func_reg;
    logic [31:0]        s1_va_reg;
    logic [31:0]        s1_data_reg;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [31:0]        out_addr_reg;
    logic [FRAME_W-1:0] out_frame_reg;

    logic               advance;
    logic               cfg_write;
    step_t              step;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready         = !s1_valid_reg || advance;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_kind  = out_kind_reg;
    assign out_ch.read_addr    = out_addr_reg;
    assign out_ch.frame_number = out_frame_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_TTB0:  prdata = cfg_reg.table_base_zero;
            REG_TTB1:  prdata = cfg_reg.table_base_one;
            REG_SPLIT: prdata = {29'd0, cfg_reg.split_width};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TTB0:  cfg_reg.table_base_zero <= pwdata;
                REG_TTB1:  cfg_reg.table_base_one  <= pwdata;
                REG_SPLIT: cfg_reg.split_width     <= pwdata[2:0];
                default:   cfg_reg <= cfg_reg;
            endcase
        end
    end

    sdpw_step u_step (
        .cfg       (cfg_reg),
        .phase     (phase_reg),
        .held_va   (held_va_reg),
        .func      (s1_func_reg),
        .virt_addr (s1_va_reg),
        .read_data (s1_data_reg),
        .res       (step)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_func_reg <= in_ch.func;
            s1_va_reg   <= in_ch.virt_addr;
            s1_data_reg <= in_ch.read_data;
        end
    end

    // walk state and result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_IDLE;
            held_va_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= step.phase_next;
                if (step.capture_va)
                begin
                    held_va_reg <= s1_va_reg;
                end
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg  <= step.kind;
            out_addr_reg  <= step.read_addr;
            out_frame_reg <= step.frame_number;
        end
    end

    `SDPW_ASSERT_NEXT(a_start_walk, clk, rst_n,
        advance && !s1_func_reg && phase_reg == PHASE_IDLE,
        phase_reg == PHASE_FIRST && held_va_reg == $past(s1_va_reg),
        "translate from idle did not start a walk")
    `SDPW_ASSERT_NEXT(a_busy_keeps_va, clk, rst_n,
        advance && !s1_func_reg && phase_reg != PHASE_IDLE,
        held_va_reg == $past(held_va_reg) && phase_reg == $past(phase_reg),
        "translate while busy disturbed the walk")
    `SDPW_ASSERT_NEXT(a_end_to_idle, clk, rst_n,
        advance && (step.kind == KIND_DONE || step.kind == KIND_FAULT),
        phase_reg == PHASE_IDLE,
        "walk end did not return to idle")
    `SDPW_ASSERT_NOW(a_addr_only_on_read, clk, rst_n,
        out_valid_reg && out_kind_reg != KIND_READ,
        out_addr_reg == 32'd0,
        "read address set on a non-read result")

endmodule

// ----- dv/short_descriptor_page_walker_tb.sv -----
// self-checking testbench for the short-descriptor page walker: directed table, then random walks
// under eight register settings; results checked against typed table rows or an in-bench predictor
// depends on sdpw_pkg, the sdpw channel interfaces and the short_descriptor_page_walker top level
module short_descriptor_page_walker_tb;
    import sdpw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        FUNC_XLATE     = 1'b0;
    localparam logic        FUNC_RESP      = 1'b1;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned WORDS_PER_SET  = 162;
    localparam int unsigned REPORT_CAP     = 50;

    typedef struct packed {
        kind_t              kind;
        logic [31:0]        read_addr;
        logic [FRAME_W-1:0] frame_number;
    } walk_result_t;

    typedef struct packed {
        logic               func;
        logic [31:0]        va;
        logic [31:0]        desc;
        logic               typed;
        kind_t              kind;
        logic [31:0]        addr;
        logic [FRAME_W-1:0] frame;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    sdpw_in_if  word_in ();
    sdpw_out_if word_out ();

    short_descriptor_page_walker dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (word_in),
        .out_ch  (word_out)
    );

    // walker state as the predictor sees it
    cfg_t        walker_cfg = '0;
    phase_t      walk_phase = PHASE_IDLE;
    logic [31:0] held_va    = '0;

    walk_result_t pending_results [$];

    int unsigned mismatches      = 0;
    int unsigned words_in        = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used   = 0;
    int unsigned cycles          = 0;
    logic        src_calm        = 1'b0;
    logic        sink_calm       = 1'b0;
    logic        sink_hold       = 1'b0;

    stim_row_t directed_rows [21] = '{
        '{FUNC_RESP,  32'h0000_0000, 32'h0000_0000, 1'b1, KIND_UNEXPECTED, 32'h0, 20'h0},
        '{FUNC_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_READ, 32'h0000_3FFC, 20'h0},
        '{FUNC_XLATE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_UNEXPECTED, 32'h0, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'h0000_0000, 1'b1, KIND_FAULT, 32'h0, 20'h0},
        '{FUNC_XLATE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_READ, 32'h0, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'hFFF0_0002, 1'b1, KIND_DONE, 32'h0, 20'hFFF00},
        '{FUNC_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_READ, 32'h0000_3FFC, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'h0004_0002, 1'b1, KIND_FAULT, 32'h0, 20'h0},
        '{FUNC_XLATE, 32'h1234_5678, 32'h0000_0000, 1'b0, KIND_READ, 32'h0, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'hABCD_E001, 1'b0, KIND_READ, 32'h0, 20'h0},
        '{FUNC_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_UNEXPECTED, 32'h0, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'h0000_0000, 1'b1, KIND_FAULT, 32'h0, 20'h0},
        '{FUNC_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_READ, 32'h0000_3FFC, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'hFFFF_FC01, 1'b1, KIND_READ, 32'hFFFF_FFFC, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'hFFFF_0001, 1'b1, KIND_DONE, 32'h0, 20'hFFFFF},
        '{FUNC_XLATE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_READ, 32'h0, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'h0000_0001, 1'b1, KIND_READ, 32'h0, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'hFFFF_F003, 1'b1, KIND_DONE, 32'h0, 20'hFFFFF},
        '{FUNC_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_READ, 32'h0000_3FFC, 20'h0},
        '{FUNC_RESP,  32'h0000_0000, 32'h0000_0003, 1'b1, KIND_DONE, 32'h0, 20'h000FF},
        '{FUNC_RESP,  32'h0000_0000, 32'h0004_0003, 1'b1, KIND_UNEXPECTED, 32'h0, 20'h0}
    };

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic walk_result_t walk_step(input logic func, input logic [31:0] va_in,
                                               input logic [31:0] desc);
        walk_result_t res;
        logic [31:0]  phys;
        int unsigned  n;
        res  = '{kind: KIND_UNEXPECTED, read_addr: '0, frame_number: '0};
        phys = '0;
        n    = walker_cfg.split_width;
        if (func == FUNC_XLATE)
        begin
            if (walk_phase == PHASE_IDLE)
            begin
                held_va    = va_in;
                walk_phase = PHASE_FIRST;
                res.kind   = KIND_READ;
                if (n != 0 && (va_in >> (32 - n)) != 0)
                    res.read_addr = {walker_cfg.table_base_one[31:14], va_in[31:20], 2'b00};
                else
                    res.read_addr = (walker_cfg.table_base_zero & ~((32'd1 << (14 - n)) - 32'd1))
                                  | (((va_in >> 20) & ((32'd1 << (12 - n)) - 32'd1)) << 2);
            end
        end
        else if (walk_phase == PHASE_FIRST)
        begin
            walk_phase = PHASE_IDLE;
            if (desc[1:0] == DESC_FAULT)
                res.kind = KIND_FAULT;
            else if (desc[1:0] == DESC_LINK)
            begin
                walk_phase    = PHASE_SECOND;
                res.kind      = KIND_READ;
                res.read_addr = {desc[31:10], held_va[19:12], 2'b00};
            end
            else if (desc[18])
                res.kind = KIND_FAULT;
            else
            begin
                res.kind = KIND_DONE;
                phys     = {desc[31:20], held_va[19:0]};
            end
        end
        else if (walk_phase == PHASE_SECOND)
        begin
            walk_phase = PHASE_IDLE;
            if (desc[1:0] == DESC_FAULT)
                res.kind = KIND_FAULT;
            else if (desc[1:0] == DESC_LINK)
            begin
                res.kind = KIND_DONE;
                phys     = {desc[31:16], held_va[15:0]};
            end
            else
            begin
                res.kind = KIND_DONE;
                phys     = {desc[31:12], held_va[11:0]};
            end
        end
        res.frame_number = phys[31:PAGE_BITS];
        return res;
    endfunction

    function automatic stim_row_t word(input logic func, input logic [31:0] va,
                                       input logic [31:0] desc);
        stim_row_t row;
        row = '{func, va, desc, 1'b0, KIND_READ, 32'h0, '0};
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < REPORT_CAP)
            $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
        mismatches++;
    endtask

    // valid is only lowered when a gap follows, so back-to-back words keep it high
    task automatic send_word(input stim_row_t row);
        int unsigned  gap;
        walk_result_t want;
        gap = src_calm ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            word_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_in.valid     <= 1'b1;
        word_in.func      <= row.func;
        word_in.virt_addr <= row.va;
        word_in.read_data <= row.desc;
        @(posedge clk);
        while (!word_in.ready) @(posedge clk);
        want = walk_step(row.func, row.va, row.desc);
        if (row.typed)
            want = '{kind: row.kind, read_addr: row.addr, frame_number: row.frame};
        pending_results.push_back(want);
        words_in++;
    endtask

    task automatic settle();
        word_in.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // leaves psel high so back-to-back writes need no release cycle
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (idx)
            REG_TTB0:  walker_cfg.table_base_zero = val;
            REG_TTB1:  walker_cfg.table_base_one  = val;
            REG_SPLIT: walker_cfg.split_width     = val[2:0];
            default: ;
        endcase
    endtask

    task automatic set_walker(input logic [31:0] base0, input logic [31:0] base1,
                              input logic [2:0] split);
        cfg_write(REG_TTB0, base0);
        cfg_write(REG_TTB1, base1);
        cfg_write(REG_SPLIT, {29'b0, split});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // mostly well-formed walks with random content, plus stray and busy words
    task automatic run_walk();
        logic [31:0] va;
        logic [31:0] desc;
        va = $urandom;
        if ($urandom_range(0, 3) == 0)
            va = va & (32'hFFFF_FFFF >> walker_cfg.split_width);
        if ($urandom_range(0, 4) == 0)
            src_calm = !src_calm;
        send_word(word(FUNC_XLATE, va, $urandom));
        if ($urandom_range(0, 9) == 0)
            send_word(word(FUNC_XLATE, $urandom, $urandom));
        desc = $urandom;
        case ($urandom_range(0, 3))
            0: desc[1:0] = DESC_FAULT;
            1: desc[1:0] = DESC_LINK;
            2:
            begin
                desc[1]  = 1'b1;
                desc[18] = 1'b0;
            end
            default: ;
        endcase
        send_word(word(FUNC_RESP, $urandom, desc));
        if (desc[1:0] == DESC_LINK)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(word(FUNC_XLATE, $urandom, $urandom));
            send_word(word(FUNC_RESP, $urandom, $urandom));
        end
        if ($urandom_range(0, 9) == 0)
            send_word(word(FUNC_RESP, $urandom, $urandom));
    endtask

    // result side: random stalls, long hold-off when asked
    initial
    begin
        int unsigned  stall;
        walk_result_t want;
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 3);
            if (stall != 0 || sink_hold)
            begin
                word_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (sink_hold) @(posedge clk);
            end
            word_out.ready <= 1'b1;
            @(posedge clk);
            while (!word_out.valid) @(posedge clk);
            if (pending_results.size() == 0)
                flag_mismatch("unrequested result_kind", word_out.result_kind, 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (word_out.result_kind !== want.kind)
                    flag_mismatch("result_kind", word_out.result_kind, want.kind);
                if (word_out.read_addr !== want.read_addr)
                    flag_mismatch("read_addr", word_out.read_addr, want.read_addr);
                if (word_out.frame_number !== want.frame_number)
                    flag_mismatch("frame_number", word_out.frame_number, want.frame_number);
            end
            results_checked++;
            if ($urandom_range(0, 19) == 0)
                sink_calm = !sink_calm;
        end
    end

    // hold the result side off while words keep coming, so both stages fill
    initial
    begin
        wait (words_in >= 400);
        @(posedge clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    initial
    begin
        logic [31:0] base0;
        logic [31:0] base1;
        int unsigned set_start;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        word_in.valid     <= 1'b0;
        word_in.func      <= FUNC_XLATE;
        word_in.virt_addr <= '0;
        word_in.read_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        for (int p = 0; p < 8; p++)
        begin
            settle();
            case (p % 3)
                0:       base0 = 32'hFFFF_FFFF;
                1:       base0 = 32'h0000_0000;
                default: base0 = $urandom;
            endcase
            case (p % 3)
                1:       base1 = 32'hFFFF_FFFF;
                2:       base1 = 32'h0000_0000;
                default: base1 = $urandom;
            endcase
            set_walker(base0, base1, p[2:0]);
            set_start = words_in;
            while (words_in - set_start < WORDS_PER_SET)
                run_walk();
        end

        settle();
        repeat (4) @(posedge clk);
        $display("sent %0d words over %0d register settings and all eight split widths",
                 words_in, settings_used);
        $display("checked %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sdpw_pkg.sv
rtl/sdpw_channels.sv
rtl/sdpw_step.sv
rtl/short_descriptor_page_walker.sv
dv/short_descriptor_page_walker_tb.sv
